[src/plcr_pkg.sv]
// shared types, constants and helpers of the piecewise linear color ramp
package plcr_pkg;

    // stop table geometry
    localparam int STOPS         = 4;
    localparam int HW_STOP_REGS  = 4;
    localparam int STOP_LIM      = (STOPS < HW_STOP_REGS) ? STOPS : HW_STOP_REGS;
    localparam int STOP_W        = 48;
    localparam int POS_W         = 16;
    localparam int CHAN_W        = 8;
    localparam int FRAC_W        = 16;

    // divider pipeline shape
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES         = FRAC_W / DIV_BITS_PER_STAGE;

    // configuration register indexes
    localparam logic [2:0] CFG_STOP_COUNT = 3'd0;
    localparam logic [2:0] CFG_STOP_0     = 3'd1;
    localparam logic [2:0] CFG_STOP_3     = 3'd4;

    // configuration reset values
    localparam logic [2:0]        RST_STOP_COUNT = 3'd2;
    localparam logic [STOP_W-1:0] RST_STOP_0     = 48'h0000_0000_00FF;
    localparam logic [STOP_W-1:0] RST_STOP_1     = 48'h0100_FFFF_FFFF;
    localparam logic [STOP_W-1:0] RST_STOP_2     = 48'h0;
    localparam logic [STOP_W-1:0] RST_STOP_3     = 48'h0;

    // sideband that travels with an item through the divider
    typedef struct packed {
        logic       interp;
        logic [1:0] idx;
    } t_side;

    // color channel of a packed stop, 0 red .. 3 alpha
    function automatic logic [CHAN_W-1:0] stop_chan(input logic [STOP_W-1:0] s,
                                                    input logic [1:0] c);
        logic [CHAN_W-1:0] ch;
        case (c)
            2'd0:    ch = s[31:24];
            2'd1:    ch = s[23:16];
            2'd2:    ch = s[15:8];
            default: ch = s[7:0];
        endcase
        return ch;
    endfunction

endpackage

[src/piecewise_linear_color_ramp_unit.sv]
// top level of the piecewise linear color ramp: stop search, divider and channel lerp
//
//  channel   valid / ready                payload
//  input     i_valid / o_ready            i_value (signed Q8.8)
//  output    o_valid / i_ready            o_red, o_green, o_blue, o_alpha
//  config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// one transaction per clock sustained while the output is not stalled; 13 register
// stages: input, stop search, segment subtract, 8 divider stages (2 quotient bits
// each), channel multiply, channel add. every stage has its own valid bit and loads
// when empty or draining, so bubbles close up under an output stall.
// synchronous active-low reset clears valid bits and loads the default stops.
module piecewise_linear_color_ramp_unit
    import plcr_pkg::*;
#(
    parameter int N_STOPS = STOPS
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [15:0]  i_value,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [7:0]          o_alpha,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [STOP_W-1:0]   i_cfg_data
);

    // active stops can never exceed the stop registers
    localparam int ACT_STOPS = (N_STOPS < HW_STOP_REGS) ? N_STOPS : HW_STOP_REGS;

    // configuration registers
    logic [2:0]              r_stop_count;
    logic [STOP_W-1:0]       r_stop [HW_STOP_REGS];
    logic [1:0]              n_stop_sel;

    // pipeline registers
    logic                    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [POS_W-1:0] r1_value, r2_value;
    t_side                   r2_side, r3_side, r4_side;
    logic [POS_W-1:0]        r3_num, r3_den;
    logic signed [25:0]      r4_prod [4];
    logic [CHAN_W-1:0]       r5_chan [4];

    logic                    w_take1, w_take2, w_take3, w_take4, w_take5;
    logic                    w_div_ready, w_div_valid;
    logic [FRAC_W-1:0]       w_div_frac;
    t_side                   w_div_side;

    logic signed [POS_W-1:0] w_pos [HW_STOP_REGS];
    logic [2:0]              w_cnt;
    t_side                   n2_side;
    logic [1:0]              w_from3;
    logic [POS_W-1:0]        n3_num, n3_den;
    logic [1:0]              w_from4;
    logic signed [25:0]      n4_prod [4];
    logic [1:0]              w_from5;
    logic [CHAN_W-1:0]       n5_chan [4];

    // configuration port, always ready
    assign o_cfg_ready = 1'b1;
    assign n_stop_sel  = 2'(i_cfg_index - CFG_STOP_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= RST_STOP_COUNT;
            r_stop[0]    <= RST_STOP_0;
            r_stop[1]    <= RST_STOP_1;
            r_stop[2]    <= RST_STOP_2;
            r_stop[3]    <= RST_STOP_3;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STOP_COUNT) begin
                r_stop_count <= i_cfg_data[2:0];
            end else if (i_cfg_index >= CFG_STOP_0 && i_cfg_index <= CFG_STOP_3) begin
                r_stop[n_stop_sel] <= i_cfg_data;
            end
        end
    end

    // stop positions and saturated active count
    always_comb begin
        for (int k = 0; k < HW_STOP_REGS; k++) begin
            w_pos[k] = signed'(r_stop[k][47:32]);
        end
        if (r_stop_count == 3'd0) begin
            w_cnt = 3'd1;
        end else if (r_stop_count > 3'(ACT_STOPS)) begin
            w_cnt = 3'(ACT_STOPS);
        end else begin
            w_cnt = r_stop_count;
        end
    end

    // ready chain, a stage loads when empty or when it drains
    assign w_take5 = !r_v5 || i_ready;
    assign w_take4 = !r_v4 || w_take5;
    assign w_take3 = !r_v3 || w_div_ready;
    assign w_take2 = !r_v2 || w_take3;
    assign w_take1 = !r_v1 || w_take2;
    assign o_ready = w_take1;

    // stop search: clamp below first stop, first stop at or above value, else last
    always_comb begin
        logic found;
        found          = 1'b0;
        n2_side.interp = 1'b0;
        n2_side.idx    = 2'(w_cnt - 3'd1);
        if (r1_value < w_pos[0]) begin
            n2_side.idx = 2'd0;
        end else begin
            for (int i = 1; i < HW_STOP_REGS; i++) begin
                if (!found && i < int'(w_cnt) && w_pos[i] >= r1_value) begin
                    found       = 1'b1;
                    n2_side.idx = 2'(i);
                    if (r1_value != w_pos[i] && w_pos[i] > w_pos[i-1]) begin
                        n2_side.interp = 1'b1;
                    end
                end
            end
        end
    end

    // segment numerator and denominator, both fit 16 bits unsigned
    assign w_from3 = r2_side.idx - 2'd1;
    assign n3_num  = r2_value - w_pos[w_from3];
    assign n3_den  = w_pos[r2_side.idx] - w_pos[w_from3];

    // fraction divider
    plcr_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (w_div_ready),
        .i_num   (r3_num),
        .i_den   (r3_den),
        .i_side  (r3_side),
        .o_valid (w_div_valid),
        .i_ready (w_take4),
        .o_frac  (w_div_frac),
        .o_side  (w_div_side)
    );

    // channel multiply: (to - from) * frac
    assign w_from4 = w_div_side.idx - 2'd1;
    always_comb begin
        logic signed [8:0] diff;
        for (int c = 0; c < 4; c++) begin
            diff = signed'({1'b0, stop_chan(r_stop[w_div_side.idx], 2'(c))})
                 - signed'({1'b0, stop_chan(r_stop[w_from4], 2'(c))});
            n4_prod[c] = diff * signed'({1'b0, w_div_frac});
        end
    end

    // channel add: from + floor(product / 65536), or the stop color directly
    assign w_from5 = r4_side.idx - 2'd1;
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            if (r4_side.interp) begin
                n5_chan[c] = stop_chan(r_stop[w_from5], 2'(c)) + r4_prod[c][23:16];
            end else begin
                n5_chan[c] = stop_chan(r_stop[r4_side.idx], 2'(c));
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_take1) r_v1 <= i_valid;
            if (w_take2) r_v2 <= r_v1;
            if (w_take3) r_v3 <= r_v2;
            if (w_take4) r_v4 <= w_div_valid;
            if (w_take5) r_v5 <= r_v4;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (w_take1) begin
            r1_value <= i_value;
        end
        if (w_take2) begin
            r2_value <= r1_value;
            r2_side  <= n2_side;
        end
        if (w_take3) begin
            r3_num  <= n3_num;
            r3_den  <= n3_den;
            r3_side <= r2_side;
        end
        if (w_take4) begin
            r4_prod <= n4_prod;
            r4_side <= w_div_side;
        end
        if (w_take5) begin
            r5_chan <= n5_chan;
        end
    end

    assign o_valid = r_v5;
    assign o_red   = r5_chan[0];
    assign o_green = r5_chan[1];
    assign o_blue  = r5_chan[2];
    assign o_alpha = r5_chan[3];

    // input stalls only behind a result that is waiting
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled without a waiting result");

    // an interpolated segment never starts before stop zero
    a_interp_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r2_side.interp) |-> (r2_side.idx != 2'd0))
        else $error("interpolation selected with stop zero as segment end");

    // saturated stop count stays in range
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cnt >= 3'd1) && (w_cnt <= 3'(ACT_STOPS)))
        else $error("active stop count out of range");

endmodule

[src/plcr_divider.sv]
// pipelined restoring divider giving an unsigned Q0.16 fraction num/den, num < den
module plcr_divider
    import plcr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [POS_W-1:0]    i_num,
    input  logic [POS_W-1:0]    i_den,
    input  t_side               i_side,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [FRAC_W-1:0]   o_frac,
    output t_side               o_side
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [POS_W-1:0]      r_rem  [DIV_STAGES];
    logic [POS_W-1:0]      r_den  [DIV_STAGES];
    logic [FRAC_W-1:0]     r_quo  [DIV_STAGES];
    t_side                 r_side [DIV_STAGES];

    logic [DIV_STAGES:0]   w_take;
    logic [POS_W-1:0]      n_rem  [DIV_STAGES];
    logic [FRAC_W-1:0]     n_quo  [DIV_STAGES];

    logic [DIV_STAGES-1:0] w_vld_in;
    logic [POS_W-1:0]      w_rem_in  [DIV_STAGES];
    logic [POS_W-1:0]      w_den_in  [DIV_STAGES];
    logic [FRAC_W-1:0]     w_quo_in  [DIV_STAGES];
    t_side                 w_side_in [DIV_STAGES];

    // per-stage ready chain, a stage loads when empty or when it drains
    always_comb begin
        w_take[DIV_STAGES] = i_ready;
        for (int k = DIV_STAGES - 1; k >= 0; k--) begin
            w_take[k] = !r_vld[k] || w_take[k+1];
        end
    end

    assign o_ready = w_take[0];

    // what each stage sees at its input: the port for the first, else the stage before
    always_comb begin
        w_vld_in[0]  = i_valid;
        w_rem_in[0]  = i_num;
        w_den_in[0]  = i_den;
        w_quo_in[0]  = '0;
        w_side_in[0] = i_side;
        for (int k = 1; k < DIV_STAGES; k++) begin
            w_vld_in[k]  = r_vld[k-1];
            w_rem_in[k]  = r_rem[k-1];
            w_den_in[k]  = r_den[k-1];
            w_quo_in[k]  = r_quo[k-1];
            w_side_in[k] = r_side[k-1];
        end
    end

    // two shift-subtract steps per stage
    always_comb begin
        logic [POS_W-1:0]  rem;
        logic [POS_W-1:0]  den;
        logic [FRAC_W-1:0] quo;
        logic [POS_W:0]    t;
        for (int k = 0; k < DIV_STAGES; k++) begin
            rem = w_rem_in[k];
            den = w_den_in[k];
            quo = w_quo_in[k];
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                t = {rem, 1'b0};
                if (t >= {1'b0, den}) begin
                    rem = POS_W'(t - {1'b0, den});
                    quo = {quo[FRAC_W-2:0], 1'b1};
                end else begin
                    rem = t[POS_W-1:0];
                    quo = {quo[FRAC_W-2:0], 1'b0};
                end
            end
            n_rem[k] = rem;
            n_quo[k] = quo;
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                if (w_take[k]) begin
                    r_vld[k] <= w_vld_in[k];
                end
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (w_take[k]) begin
                r_rem[k]  <= n_rem[k];
                r_quo[k]  <= n_quo[k];
                r_den[k]  <= w_den_in[k];
                r_side[k] <= w_side_in[k];
            end
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_frac  = r_quo[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule
